[rtl/i2cm_pkg.sv]
`default_nettype none

package i2cm_pkg;

    // Bit-timing tick counter width
    localparam int TICK_W = 16;

    // Command codes
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    // Sequencer step codes (0 is idle)
    localparam logic [3:0] PH_IDLE = 4'd0;
    localparam logic [3:0] PH_S1   = 4'd1;
    localparam logic [3:0] PH_S2   = 4'd2;
    localparam logic [3:0] PH_S3   = 4'd3;
    localparam logic [3:0] PH_S4   = 4'd4;
    localparam logic [3:0] PH_S5   = 4'd5;
    localparam logic [3:0] PH_S6   = 4'd6;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // Register map (index = paddr[3:2])
    localparam int          ADDR_W     = 4;
    localparam logic [1:0]  REG_UNIT   = 2'd0;
    localparam logic [1:0]  REG_ACKH   = 2'd1;
    localparam logic [1:0]  REG_RDLOW  = 2'd2;

    localparam logic [15:0] UNIT_TICKS_RESET = 16'd100;
    localparam logic [3:0]  ACK_HOLD_RESET   = 4'd10;
    localparam logic [3:0]  READ_LOW_RESET   = 4'd2;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] wr_data;
        logic       ack_to_send;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_seen;
    } t_res;

    typedef struct packed {
        logic [15:0] unit_ticks;
        logic [3:0]  ack_hold_units;
        logic [3:0]  read_low_units;
    } t_cfg;

    // Ticks per delay unit, saturated to the counter range
    function automatic logic [TICK_W-1:0] unit_load(input logic [15:0] ticks);
        logic [32:0] lim;
        logic [32:0] v;
        lim = (33'd1 << TICK_W) - 33'd1;
        v   = {17'd0, ticks};
        if (v > lim) begin
            v = lim;
        end
        return v[TICK_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/i2cm_if.sv]
`default_nettype none

// Command/pin sample channel
interface i2cm_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [7:0] wr_data;
    logic       ack_to_send;
    logic       sda_in;

    modport source (output valid, cmd, wr_data, ack_to_send, sda_in, input ready);
    modport sink   (input valid, cmd, wr_data, ack_to_send, sda_in, output ready);
endinterface

// Pin/status result channel
interface i2cm_res_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;

    modport source (output valid, scl_level, sda_drive, busy_res, done_res, rx_byte,
                    ack_seen, input ready);
    modport sink   (input valid, scl_level, sda_drive, busy_res, done_res, rx_byte,
                    ack_seen, output ready);
endinterface

`default_nettype wire

[rtl/i2cm_regs.sv]
`default_nettype none

module i2cm_regs (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [i2cm_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    output logic                           pready,
    output i2cm_pkg::t_cfg                 o_cfg
);
    import i2cm_pkg::*;

    t_cfg       r_cfg;
    logic       s_wr;
    logic [1:0] s_idx;

    assign pready = 1'b1;
    assign s_idx  = paddr[3:2];
    assign s_wr   = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.unit_ticks     <= UNIT_TICKS_RESET;
            r_cfg.ack_hold_units <= ACK_HOLD_RESET;
            r_cfg.read_low_units <= READ_LOW_RESET;
        end else if (s_wr) begin
            unique case (s_idx)
                REG_UNIT:  r_cfg.unit_ticks     <= pwdata[15:0];
                REG_ACKH:  r_cfg.ack_hold_units <= pwdata[3:0];
                REG_RDLOW: r_cfg.read_low_units <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Readback
    always_comb begin
        unique case (s_idx)
            REG_UNIT:  prdata = {16'd0, r_cfg.unit_ticks};
            REG_ACKH:  prdata = {28'd0, r_cfg.ack_hold_units};
            REG_RDLOW: prdata = {28'd0, r_cfg.read_low_units};
            default:   prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[rtl/i2cm_core.sv]
`default_nettype none

module i2cm_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  i2cm_pkg::t_item      i_item,
    input  i2cm_pkg::t_cfg       i_cfg,
    output i2cm_pkg::t_res       o_res
);
    import i2cm_pkg::*;

    logic [3:0]        r_phase, n_phase;
    logic [2:0]        r_act, n_act;
    logic [3:0]        r_bit, n_bit;
    logic [7:0]        r_shift, n_shift;
    logic [TICK_W-1:0] r_tcnt, n_tcnt;
    logic [3:0]        r_ucnt, n_ucnt;
    logic              r_scl, n_scl;
    logic              r_sda, n_sda;
    logic              r_ack, n_ack;

    logic              s_step;
    logic              s_fin;
    logic              s_wait;
    logic [3:0]        s_wait_u;
    logic [3:0]        s_nxt;
    logic [TICK_W-1:0] s_load;

    assign s_load = unit_load(i_cfg.unit_ticks);

    // Per-tick sequencer: start a command when idle, count down the current wait, or run the next step
    always_comb begin
        n_phase  = r_phase;
        n_act    = r_act;
        n_bit    = r_bit;
        n_shift  = r_shift;
        n_tcnt   = r_tcnt;
        n_ucnt   = r_ucnt;
        n_scl    = r_scl;
        n_sda    = r_sda;
        n_ack    = r_ack;
        s_step   = 1'b0;
        s_fin    = 1'b0;
        s_wait   = 1'b0;
        s_wait_u = 4'd0;
        s_nxt    = PH_IDLE;

        if (r_phase == PH_IDLE) begin
            if (i_item.cmd >= CMD_START && i_item.cmd <= CMD_READ) begin
                n_act   = i_item.cmd;
                n_bit   = 4'd0;
                n_shift = (i_item.cmd == CMD_WRITE) ? i_item.wr_data : 8'd0;
                if (i_item.cmd == CMD_READ) begin
                    n_ack = i_item.ack_to_send;
                end
                s_nxt  = PH_S1;
                s_step = 1'b1;
            end
        end else if (r_ucnt <= 4'd1 && r_tcnt <= TICK_W'(1)) begin
            s_nxt = r_phase + 4'd1;
            // loop back for the next data bit
            if ((r_act == CMD_WRITE || r_act == CMD_READ) && r_phase == PH_S3
                    && r_bit < BITS_PER_BYTE) begin
                s_nxt = (r_act == CMD_WRITE) ? PH_S1 : PH_S2;
            end
            s_step = 1'b1;
        end else if (r_tcnt <= TICK_W'(1)) begin
            n_tcnt = s_load;
            n_ucnt = r_ucnt - 4'd1;
        end else begin
            n_tcnt = r_tcnt - TICK_W'(1);
        end

        // Pin action of the step
        if (s_step) begin
            n_phase = s_nxt;
            unique case ({n_act, s_nxt})
                {CMD_START, PH_S1}: begin n_sda = 1'b1; s_wait = 1'b1; end
                {CMD_START, PH_S2}: begin n_scl = 1'b1; s_wait = 1'b1; s_wait_u = 4'd1; end
                {CMD_START, PH_S3}: begin n_sda = 1'b0; s_wait = 1'b1; end
                {CMD_START, PH_S4}: begin n_scl = 1'b0; s_fin = 1'b1; end
                {CMD_STOP,  PH_S1}: begin n_scl = 1'b0; s_wait = 1'b1; end
                {CMD_STOP,  PH_S2}: begin n_sda = 1'b0; s_wait = 1'b1; s_wait_u = 4'd1; end
                {CMD_STOP,  PH_S3}: begin n_scl = 1'b1; s_wait = 1'b1; s_wait_u = 4'd1; end
                {CMD_STOP,  PH_S4}: begin n_sda = 1'b1; s_fin = 1'b1; end
                {CMD_WRITE, PH_S1}: begin
                    n_sda    = n_shift[7];
                    n_shift  = {n_shift[6:0], 1'b0};
                    s_wait   = 1'b1;
                    s_wait_u = 4'd1;
                end
                {CMD_WRITE, PH_S2}: begin n_scl = 1'b1; s_wait = 1'b1; s_wait_u = 4'd1; end
                {CMD_WRITE, PH_S3}: begin
                    n_scl  = 1'b0;
                    n_bit  = r_bit + 4'd1;
                    s_wait = 1'b1;
                end
                {CMD_WRITE, PH_S4}: begin n_sda = 1'b1; s_wait = 1'b1; s_wait_u = 4'd1; end
                {CMD_WRITE, PH_S5}: begin
                    n_scl    = 1'b1;
                    s_wait   = 1'b1;
                    s_wait_u = i_cfg.ack_hold_units;
                end
                {CMD_WRITE, PH_S6}: begin
                    n_ack = i_item.sda_in;
                    n_scl = 1'b0;
                    s_fin = 1'b1;
                end
                {CMD_READ,  PH_S1}: begin n_sda = 1'b1; s_wait = 1'b1; end
                {CMD_READ,  PH_S2}: begin n_scl = 1'b1; s_wait = 1'b1; s_wait_u = 4'd1; end
                {CMD_READ,  PH_S3}: begin
                    n_shift  = {n_shift[6:0], i_item.sda_in};
                    n_scl    = 1'b0;
                    n_bit    = r_bit + 4'd1;
                    s_wait   = 1'b1;
                    s_wait_u = i_cfg.read_low_units;
                end
                {CMD_READ,  PH_S4}: begin n_sda = n_ack; s_wait = 1'b1; s_wait_u = 4'd1; end
                {CMD_READ,  PH_S5}: begin n_scl = 1'b1; s_wait = 1'b1; s_wait_u = 4'd1; end
                {CMD_READ,  PH_S6}: begin n_scl = 1'b0; s_fin = 1'b1; end
                default:            s_fin = 1'b1;
            endcase
        end

        // Load the wait; zero units means a single tick
        if (s_wait) begin
            n_ucnt = s_wait_u;
            n_tcnt = (s_wait_u != 4'd0) ? s_load : '0;
        end

        if (s_fin) begin
            n_phase = PH_IDLE;
        end
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_act   <= CMD_NONE;
            r_bit   <= 4'd0;
            r_shift <= 8'd0;
            r_tcnt  <= '0;
            r_ucnt  <= 4'd0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_ack   <= 1'b1;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_act   <= n_act;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_tcnt  <= n_tcnt;
            r_ucnt  <= n_ucnt;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_ack   <= n_ack;
        end
    end

    // Result of this tick
    always_comb begin
        o_res.scl_level = n_scl;
        o_res.sda_drive = n_sda;
        o_res.busy_res  = (n_phase != PH_IDLE);
        o_res.done_res  = s_fin;
        o_res.rx_byte   = (s_fin && n_act == CMD_READ) ? n_shift : 8'd0;
        o_res.ack_seen  = s_fin && n_act == CMD_WRITE && n_ack;
    end

endmodule

`default_nettype wire

[rtl/i2c_byte_master.sv]
// Datapath: an accepted tick item waits in the input register; the
//   sequencer takes one step per item into the result register as it frees.
// Throughput: one item per cycle unless o_res.ready holds the result slot.
// Reset: synchronous, active low; sequencer idle, SCL and SDA released,
//   timing registers at their defaults, both pipeline registers empty.
`default_nettype none

module i2c_byte_master (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    i2cm_item_if.sink                        i_item,
    i2cm_res_if.source                       o_res,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [i2cm_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);
    import i2cm_pkg::*;

    logic  r_in_valid;
    t_item r_in;
    logic  r_out_valid;
    t_res  r_out;
    logic  s_adv;
    t_cfg  s_cfg;
    t_res  s_res;

    i2cm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (s_cfg)
    );

    // Step the sequencer when an input is held and the result slot frees up
    assign s_adv        = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_item.ready = !r_in_valid || s_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in.cmd         <= i_item.cmd;
            r_in.wr_data     <= i_item.wr_data;
            r_in.ack_to_send <= i_item.ack_to_send;
            r_in.sda_in      <= i_item.sda_in;
        end
    end

    i2cm_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_adv),
        .i_item  (r_in),
        .i_cfg   (s_cfg),
        .o_res   (s_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            r_out <= s_res;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.scl_level = r_out.scl_level;
    assign o_res.sda_drive = r_out.sda_drive;
    assign o_res.busy_res  = r_out.busy_res;
    assign o_res.done_res  = r_out.done_res;
    assign o_res.rx_byte   = r_out.rx_byte;
    assign o_res.ack_seen  = r_out.ack_seen;

    // A completing tick never reports busy
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.done_res |-> !r_out.busy_res)
        else $error("done and busy together");

    // Read data and ack only appear with done
    a_data_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.done_res |-> r_out.rx_byte == 8'd0 && !r_out.ack_seen)
        else $error("result data outside a done tick");

    // An empty result slot never blocks the input side
    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_item.ready)
        else $error("input stalled with empty result register");

    // A step taken moves a result into the register
    a_adv_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_adv |=> r_out_valid)
        else $error("step lost its result");

endmodule

`default_nettype wire
